/* sv/wemf_pkg.sv */
// ----------------------------------------------------------------------------
// wemf_pkg
// shared types and constants of the windowed ema macd filter
// ----------------------------------------------------------------------------
package wemf_pkg;

    localparam int ACC_W   = 32;                    // element and accumulator width
    localparam int ALPHA_W = 16;                    // unsigned q0.16 weight
    localparam int DIFF_W  = ACC_W + 1;
    localparam int PROD_W  = DIFF_W + ALPHA_W + 1;
    localparam int ADDR_W  = 4;                     // apb byte address
    localparam int DATA_W  = 32;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_FAST_ALPHA   = 2'd0;
    localparam logic [1:0] REG_SLOW_ALPHA   = 2'd1;
    localparam logic [1:0] REG_SIGNAL_ALPHA = 2'd2;

    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 16'd10082;
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 16'd4855;
    localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 16'd13107;

    // multiply-accumulate step control
    typedef struct packed {
        logic load;   // acc takes the oldest element
        logic mul;    // product of (element - acc) and alpha
        logic acc;    // acc takes acc + rounded product
    } mac_ctl_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FETCH = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_ACC   = 7'b0010000,
        ST_DIFF  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PASS_FAST   = 2'd0,
        PASS_SLOW   = 2'd1,
        PASS_SIGNAL = 2'd2
    } pass_t;

endpackage

/* sv/wemf_mac.sv */
// ----------------------------------------------------------------------------
// wemf_mac
// shared multiply-accumulate of the windowed ema recurrence
// acc = acc + floor(((x - acc) * alpha + 2^15) / 2^16)
// ----------------------------------------------------------------------------
module wemf_mac
    import wemf_pkg::*;
(
    input  logic                     aclk,
    input  mac_ctl_t                 ctl,
    input  logic signed [ACC_W-1:0]  elem,
    input  logic [ALPHA_W-1:0]       alpha,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [ALPHA_W:0]   alpha_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [DIFF_W:0]    part;
    logic signed [DIFF_W:0]    sum;

    assign diff      = DIFF_W'(elem) - DIFF_W'(acc_reg);
    assign alpha_s   = $signed({1'b0, alpha});
    assign prod_next = PROD_W'(diff) * PROD_W'(alpha_s);

    // round half up, then arithmetic shift keeps the floor
    assign prod_rnd = (prod_reg + PROD_W'(32768)) >>> ALPHA_W;
    assign part     = prod_rnd[DIFF_W:0];
    assign sum      = (DIFF_W + 1)'(acc_reg) + part;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= elem;
        end else if (ctl.acc) begin
            // result stays between the window extremes, so 32 bits hold it
            acc_reg <= sum[ACC_W-1:0];
        end
        if (ctl.mul) begin
            prod_reg <= prod_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* sv/windowed_ema_macd_filter.sv */
// ----------------------------------------------------------------------------
// windowed_ema_macd_filter
// macd of a price stream: fast minus slow windowed ema of the prices, and a
// windowed ema of the macd series, all kept in two circular window memories
// ----------------------------------------------------------------------------
//  channel  ports                          word
//  input    s_valid s_ready                s_price_sample
//  result   m_valid m_ready                m_macd_value m_signal_value
//                                          m_macd_valid m_signal_valid
//  config   psel penable pwrite pready     paddr pwdata prdata
//
//  one word at a time; each window element goes through the shared
//  multiply-accumulate. a word runs the fast, slow and signal passes once both
//  windows are full, the fast and slow passes while only the price window is
//  full, and no pass before that.
//  reset clears the sample count and pointers, restores default weights; window
//  memories are not cleared. a stalled result waits in the output register.
// ----------------------------------------------------------------------------
module windowed_ema_macd_filter
    import wemf_pkg::*;
#(
    parameter int FAST_WINDOW   = 12,
    parameter int SLOW_WINDOW   = 26,
    parameter int SIGNAL_WINDOW = 9,
    parameter int SAMPLE_BITS   = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [31:0]       s_price_sample,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_macd_value,
    output logic signed [31:0]       m_signal_value,
    output logic                     m_macd_valid,
    output logic                     m_signal_valid
);

    localparam int PRICE_DEPTH = (FAST_WINDOW > SLOW_WINDOW) ? FAST_WINDOW : SLOW_WINDOW;
    localparam int IN_BITS     = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam int SEEN_MAX    = PRICE_DEPTH + SIGNAL_WINDOW - 1;
    localparam int SEEN_W      = $clog2(SEEN_MAX + 1);
    localparam int PA_W        = $clog2(PRICE_DEPTH);
    localparam int MA_W        = $clog2(SIGNAL_WINDOW);
    localparam int MAX_WIN     = (PRICE_DEPTH > SIGNAL_WINDOW) ? PRICE_DEPTH : SIGNAL_WINDOW;
    localparam int CNT_W       = $clog2(MAX_WIN);

    // ---------------------------------------------------------------- config
    logic [ALPHA_W-1:0] fast_alpha_reg;
    logic [ALPHA_W-1:0] slow_alpha_reg;
    logic [ALPHA_W-1:0] signal_alpha_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_alpha_reg   <= FAST_ALPHA_RST;
            slow_alpha_reg   <= SLOW_ALPHA_RST;
            signal_alpha_reg <= SIGNAL_ALPHA_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FAST_ALPHA:   fast_alpha_reg   <= pwdata[ALPHA_W-1:0];
                REG_SLOW_ALPHA:   slow_alpha_reg   <= pwdata[ALPHA_W-1:0];
                REG_SIGNAL_ALPHA: signal_alpha_reg <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FAST_ALPHA:   prdata = DATA_W'(fast_alpha_reg);
            REG_SLOW_ALPHA:   prdata = DATA_W'(slow_alpha_reg);
            REG_SIGNAL_ALPHA: prdata = DATA_W'(signal_alpha_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- registers
    state_t                   state_reg, state_next;
    pass_t                    pass_reg, pass_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [PA_W-1:0]          price_wptr_reg, price_wptr_next;
    logic [PA_W-1:0]          prd_addr_reg, prd_addr_next;
    logic [MA_W-1:0]          macd_wptr_reg, macd_wptr_next;
    logic [MA_W-1:0]          mrd_addr_reg, mrd_addr_next;
    logic [SEEN_W-1:0]        seen_reg, seen_next;
    logic                     mv_reg, mv_next;
    logic                     sv_reg, sv_next;
    logic signed [ACC_W-1:0]  fast_reg, fast_next;
    logic signed [ACC_W-1:0]  macd_reg, macd_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [31:0]       m_macd_reg, m_signal_reg;
    logic                     m_mv_reg, m_sv_reg;
    logic                     out_load;

    // -------------------------------------------------------------- memories
    logic signed [IN_BITS-1:0] price_mem [PRICE_DEPTH];
    logic signed [IN_BITS-1:0] price_rdata_reg;
    logic signed [ACC_W-1:0]   macd_mem [SIGNAL_WINDOW];
    logic signed [ACC_W-1:0]   macd_rdata_reg;
    logic                      accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            price_mem[price_wptr_reg] <= s_price_sample[IN_BITS-1:0];
        end
        price_rdata_reg <= price_mem[prd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIFF) begin
            macd_mem[macd_wptr_reg] <= macd_next;
        end
        macd_rdata_reg <= macd_mem[mrd_addr_reg];
    end

    // ------------------------------------------------------------- mac unit
    mac_ctl_t                 mac_ctl;
    logic signed [ACC_W-1:0]  mac_elem;
    logic [ALPHA_W-1:0]       mac_alpha;
    logic signed [ACC_W-1:0]  mac_acc;

    assign mac_elem = (pass_reg == PASS_SIGNAL) ? macd_rdata_reg : ACC_W'(price_rdata_reg);

    always_comb begin
        unique case (pass_reg)
            PASS_FAST:   mac_alpha = fast_alpha_reg;
            PASS_SLOW:   mac_alpha = slow_alpha_reg;
            PASS_SIGNAL: mac_alpha = signal_alpha_reg;
            default:     mac_alpha = fast_alpha_reg;
        endcase
    end

    wemf_mac u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .elem  (mac_elem),
        .alpha (mac_alpha),
        .acc   (mac_acc)
    );

    // ------------------------------------------------------- address helpers
    logic [PA_W:0]     fast_start_sum;
    logic [PA_W-1:0]   fast_start;
    logic [PA_W:0]     slow_start_sum;
    logic [PA_W-1:0]   slow_start;
    logic [PA_W-1:0]   price_wptr_inc;
    logic [PA_W-1:0]   prd_addr_inc;
    logic [MA_W-1:0]   macd_wptr_inc;
    logic [MA_W-1:0]   mrd_addr_inc;
    logic [ACC_W:0]    macd_diff;
    logic signed [ACC_W-1:0] macd_sat;

    // fast window starts FAST_WINDOW-1 entries behind the word being written
    assign fast_start_sum = {1'b0, price_wptr_reg}
                          + (PA_W + 1)'(PRICE_DEPTH - FAST_WINDOW + 1);
    assign fast_start     = (fast_start_sum >= (PA_W + 1)'(PRICE_DEPTH))
                          ? PA_W'(fast_start_sum - (PA_W + 1)'(PRICE_DEPTH))
                          : fast_start_sum[PA_W-1:0];
    // write pointer has moved on by then, one past the newest word
    assign slow_start_sum = {1'b0, price_wptr_reg}
                          + (PA_W + 1)'(PRICE_DEPTH - SLOW_WINDOW);
    assign slow_start     = (slow_start_sum >= (PA_W + 1)'(PRICE_DEPTH))
                          ? PA_W'(slow_start_sum - (PA_W + 1)'(PRICE_DEPTH))
                          : slow_start_sum[PA_W-1:0];

    assign price_wptr_inc = (price_wptr_reg == PA_W'(PRICE_DEPTH - 1)) ? '0 : price_wptr_reg + 1'b1;
    assign prd_addr_inc   = (prd_addr_reg == PA_W'(PRICE_DEPTH - 1)) ? '0 : prd_addr_reg + 1'b1;
    assign macd_wptr_inc  = (macd_wptr_reg == MA_W'(SIGNAL_WINDOW - 1)) ? '0 : macd_wptr_reg + 1'b1;
    assign mrd_addr_inc   = (mrd_addr_reg == MA_W'(SIGNAL_WINDOW - 1)) ? '0 : mrd_addr_reg + 1'b1;

    assign macd_diff = (ACC_W + 1)'(fast_reg) - (ACC_W + 1)'(mac_acc);
    always_comb begin
        if (macd_diff[ACC_W] != macd_diff[ACC_W-1]) begin
            macd_sat = macd_diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            macd_sat = macd_diff[ACC_W-1:0];
        end
    end

    // ------------------------------------------------------------- sequencer
    always_comb begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        cnt_next        = cnt_reg;
        price_wptr_next = price_wptr_reg;
        prd_addr_next   = prd_addr_reg;
        macd_wptr_next  = macd_wptr_reg;
        mrd_addr_next   = mrd_addr_reg;
        seen_next       = seen_reg;
        mv_next         = mv_reg;
        sv_next         = sv_reg;
        fast_next       = fast_reg;
        macd_next       = macd_reg;
        mac_ctl         = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    seen_next       = (seen_reg < SEEN_W'(SEEN_MAX)) ? seen_reg + 1'b1 : seen_reg;
                    mv_next         = (seen_next >= SEEN_W'(PRICE_DEPTH));
                    sv_next         = (seen_next >= SEEN_W'(SEEN_MAX));
                    macd_next       = '0;
                    price_wptr_next = price_wptr_inc;
                    prd_addr_next   = fast_start;
                    pass_next       = PASS_FAST;
                    cnt_next        = CNT_W'(FAST_WINDOW - 1);
                    state_next      = mv_next ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH: begin
                // first word of the pass is on its way out of the memory
                if (pass_reg == PASS_SIGNAL) begin
                    mrd_addr_next = mrd_addr_inc;
                end else begin
                    prd_addr_next = prd_addr_inc;
                end
                if (pass_reg == PASS_SLOW) begin
                    fast_next = mac_acc;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                mac_ctl.load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                mac_ctl.mul = 1'b1;
                if (pass_reg == PASS_SIGNAL) begin
                    mrd_addr_next = mrd_addr_inc;
                end else begin
                    prd_addr_next = prd_addr_inc;
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                mac_ctl.acc = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    unique case (pass_reg)
                        PASS_FAST: begin
                            pass_next     = PASS_SLOW;
                            prd_addr_next = slow_start;
                            cnt_next      = CNT_W'(SLOW_WINDOW - 1);
                            state_next    = ST_FETCH;
                        end
                        PASS_SLOW:   state_next = ST_DIFF;
                        PASS_SIGNAL: state_next = ST_DONE;
                        default:     state_next = ST_DONE;
                    endcase
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DIFF: begin
                macd_next      = macd_sat;
                macd_wptr_next = macd_wptr_inc;
                // oldest macd word sits right after the one written now
                mrd_addr_next  = macd_wptr_inc;
                if (sv_reg) begin
                    pass_next  = PASS_SIGNAL;
                    cnt_next   = CNT_W'(SIGNAL_WINDOW - 1);
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pass_reg       <= PASS_FAST;
            cnt_reg        <= '0;
            price_wptr_reg <= '0;
            prd_addr_reg   <= '0;
            macd_wptr_reg  <= '0;
            mrd_addr_reg   <= '0;
            seen_reg       <= '0;
            mv_reg         <= 1'b0;
            sv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            cnt_reg        <= cnt_next;
            price_wptr_reg <= price_wptr_next;
            prd_addr_reg   <= prd_addr_next;
            macd_wptr_reg  <= macd_wptr_next;
            mrd_addr_reg   <= mrd_addr_next;
            seen_reg       <= seen_next;
            mv_reg         <= mv_next;
            sv_reg         <= sv_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fast_reg <= fast_next;
        macd_reg <= macd_next;
        if (out_load) begin
            m_macd_reg   <= macd_reg;
            m_signal_reg <= sv_reg ? mac_acc : '0;
            m_mv_reg     <= mv_reg;
            m_sv_reg     <= sv_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_macd_value   = m_macd_reg;
    assign m_signal_value = m_signal_reg;
    assign m_macd_valid   = m_mv_reg;
    assign m_signal_valid = m_sv_reg;

    // ------------------------------------------------------------ assertions
    a_signal_needs_macd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_signal_valid || m_macd_valid))
        else $error("signal valid without macd valid");

    a_macd_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_macd_valid) |-> (m_macd_value == 32'sd0))
        else $error("macd value not zero before the window is full");

    a_mul_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (cnt_reg != '0))
        else $error("blend step with no element left");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> !s_ready)
        else $error("input taken in the middle of a pass");

endmodule

/* bench/tb_windowed_ema_macd_filter.sv */
// ----------------------------------------------------------------------------
// tb_windowed_ema_macd_filter
// Drives price words into the windowed ema macd filter and checks every
// result word against a predictor kept in step. It covers the window fill,
// macd saturation and extreme, zero and random weights, along with random
// idling on both channels and a long output hold-off. The apb weight
// registers are written and read back between phases.
// ----------------------------------------------------------------------------
module tb_windowed_ema_macd_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import wemf_pkg::*;

    localparam int FAST_WINDOW   = 12;
    localparam int SLOW_WINDOW   = 26;
    localparam int SIGNAL_WINDOW = 9;
    localparam int SAMPLE_BITS   = 32;
    localparam int PRICE_DEPTH   = (FAST_WINDOW > SLOW_WINDOW) ? FAST_WINDOW : SLOW_WINDOW;
    localparam int WORD_CYCLES   = 2 * (FAST_WINDOW + SLOW_WINDOW + SIGNAL_WINDOW) + 3;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int LONG_HOLD     = 800;
    localparam int MAX_REPORTS   = 40;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam logic signed [31:0] PRICE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PRICE_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] macd_value;
        logic signed [31:0] signal_value;
        logic               macd_valid;
        logic               signal_valid;
    } macd_word_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [ADDR_W-1:0]  paddr          = '0;
    logic [DATA_W-1:0]  pwdata         = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_price_sample = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_macd_value;
    logic signed [31:0] m_signal_value;
    logic               m_macd_valid;
    logic               m_signal_valid;

    // predictor state
    logic [ALPHA_W-1:0] fast_w   = FAST_ALPHA_RST;
    logic [ALPHA_W-1:0] slow_w   = SLOW_ALPHA_RST;
    logic [ALPHA_W-1:0] signal_w = SIGNAL_ALPHA_RST;
    longint             price_hist[$];
    longint             macd_hist[$];
    macd_word_t         pending_words[$];

    longint walk_price    = 0;
    int     send_idle_pct = 14;
    int     recv_idle_pct = 83;
    int     fail_count    = 0;
    int     cycle_count   = 0;
    logic   hold_active   = 1'b0;
    event   hold_off_ev;

    windowed_ema_macd_filter #(
        .FAST_WINDOW   (FAST_WINDOW),
        .SLOW_WINDOW   (SLOW_WINDOW),
        .SIGNAL_WINDOW (SIGNAL_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_price_sample (s_price_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_macd_value   (m_macd_value),
        .m_signal_value (m_signal_value),
        .m_macd_valid   (m_macd_valid),
        .m_signal_valid (m_signal_valid)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------ predictor

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(PRICE_MAX)) return PRICE_MAX;
        if (v < longint'(PRICE_MIN)) return PRICE_MIN;
        return v[31:0];
    endfunction

    // acc moves toward x by (x - acc) * alpha, rounded half up
    function automatic longint blend_toward(input longint acc, input longint x,
                                            input logic [ALPHA_W-1:0] alpha);
        longint prod;
        prod = (x - acc) * longint'(alpha);
        return acc + ((prod + 64'sd32768) >>> 16);
    endfunction

    // ema over the newest n entries, starting from the oldest of them
    function automatic longint windowed_ema(input longint vals[$], input int n,
                                            input logic [ALPHA_W-1:0] alpha);
        int     first;
        longint acc;
        first = vals.size() - n;
        acc = vals[first];
        for (int k = first + 1; k < vals.size(); k++)
            acc = blend_toward(acc, vals[k], alpha);
        return acc;
    endfunction

    function automatic macd_word_t advance_filter(input logic signed [31:0] price);
        macd_word_t w;
        longint     fast_ema;
        longint     slow_ema;
        w = '{default: 0};
        price_hist.push_back(longint'(price));
        if (price_hist.size() > PRICE_DEPTH)
            void'(price_hist.pop_front());
        if (price_hist.size() == PRICE_DEPTH) begin
            fast_ema = windowed_ema(price_hist, FAST_WINDOW, fast_w);
            slow_ema = windowed_ema(price_hist, SLOW_WINDOW, slow_w);
            w.macd_value = clamp32(fast_ema - slow_ema);
            w.macd_valid = 1'b1;
            macd_hist.push_back(longint'(w.macd_value));
            if (macd_hist.size() > SIGNAL_WINDOW)
                void'(macd_hist.pop_front());
            if (macd_hist.size() == SIGNAL_WINDOW) begin
                w.signal_value = clamp32(windowed_ema(macd_hist, SIGNAL_WINDOW, signal_w));
                w.signal_valid = 1'b1;
            end
        end
        return w;
    endfunction

    // mostly a random walk, with jumps to the rails and to arbitrary values
    function automatic logic signed [31:0] random_price();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            walk_price = longint'(PRICE_MAX);
        else if (pick == 1)
            walk_price = longint'(PRICE_MIN);
        else if (pick < 5)
            walk_price = longint'($signed($urandom));
        else
            walk_price = clamp32(walk_price + longint'($urandom_range(2097152)) - 1048576);
        return walk_price[31:0];
    endfunction

    // ------------------------------------------------------------------ reporting

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------ apb

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_FAST_ALPHA:   fast_w   = data[ALPHA_W-1:0];
            REG_SLOW_ALPHA:   slow_w   = data[ALPHA_W-1:0];
            REG_SIGNAL_ALPHA: signal_w = data[ALPHA_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_weights();
        logic [DATA_W-1:0] rd;
        apb_read(REG_FAST_ALPHA, rd);
        if (rd !== DATA_W'(fast_w))
            report_mismatch("fast_alpha readback", longint'(rd), longint'(fast_w));
        apb_read(REG_SLOW_ALPHA, rd);
        if (rd !== DATA_W'(slow_w))
            report_mismatch("slow_alpha readback", longint'(rd), longint'(slow_w));
        apb_read(REG_SIGNAL_ALPHA, rd);
        if (rd !== DATA_W'(signal_w))
            report_mismatch("signal_alpha readback", longint'(rd), longint'(signal_w));
    endtask

    task automatic set_weights(input logic [DATA_W-1:0] fast, input logic [DATA_W-1:0] slow,
                               input logic [DATA_W-1:0] sig);
        apb_write(REG_FAST_ALPHA, fast);
        apb_write(REG_SLOW_ALPHA, slow);
        apb_write(REG_SIGNAL_ALPHA, sig);
        check_weights();
    endtask

    // ------------------------------------------------------------------ price channel

    task automatic send_price(input logic signed [31:0] price);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_price_sample <= price;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_words.push_back(advance_filter(price));
    endtask

    task automatic run_random(input int count);
        repeat (count) send_price(random_price());
    endtask

    // sender stops until every expected word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------ result channel

    always @(posedge aclk) begin
        if (hold_active)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial forever begin
        @(hold_off_ev);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_active <= 1'b0;
    end

    always @(posedge aclk) begin
        macd_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("result word with none expected, macd_value",
                                longint'(m_macd_value), 0);
            end else begin
                want = pending_words.pop_front();
                if (m_macd_value !== want.macd_value)
                    report_mismatch("macd_value", longint'(m_macd_value),
                                    longint'(want.macd_value));
                if (m_signal_value !== want.signal_value)
                    report_mismatch("signal_value", longint'(m_signal_value),
                                    longint'(want.signal_value));
                if (m_macd_valid !== want.macd_valid)
                    report_mismatch("macd_valid", longint'(m_macd_valid),
                                    longint'(want.macd_valid));
                if (m_signal_valid !== want.signal_valid)
                    report_mismatch("signal_valid", longint'(m_signal_valid),
                                    longint'(want.signal_valid));
            end
        end
    end

    // ------------------------------------------------------------------ tests

    task automatic test_register_access();
        check_weights();
        set_weights(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_weights(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        set_weights(32'hA5A5_8001, 32'h5A5A_7FFE, 32'h0F0F_C3C3);
        // unmapped register must leave the weights alone
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        check_weights();
        set_weights(DATA_W'(FAST_ALPHA_RST), DATA_W'(SLOW_ALPHA_RST),
                    DATA_W'(SIGNAL_ALPHA_RST));
    endtask

    // outputs stay zero and invalid until the price window fills
    task automatic test_window_fill();
        logic signed [31:0] fill [26] = '{
            PRICE_MAX, PRICE_MIN, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001,
            32'sh0001_0000, 32'shFFFF_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF,
            PRICE_MAX, PRICE_MAX, PRICE_MIN, PRICE_MIN, 32'sh0064_0000,
            32'sh0065_8000, 32'sh0063_4000, 32'sh0066_0000, 32'sh0062_C000, 32'sh0067_2000,
            PRICE_MIN, PRICE_MIN, PRICE_MIN, PRICE_MAX, PRICE_MAX,
            PRICE_MAX
        };
        foreach (fill[i]) send_price(fill[i]);
        drain_results();
    endtask

    task automatic test_default_weights();
        run_random(450);
        drain_results();
    endtask

    // fast ema tracks the newest price, slow ema sits on the oldest one
    task automatic test_macd_saturation();
        int                 sent;
        int                 run_len;
        logic signed [31:0] level;
        set_weights(32'h0000_FFFF, 32'h0000_0000, 32'h0000_FFFF);
        sent = 0;
        while (sent < 350) begin
            level   = $urandom_range(1) ? PRICE_MAX : PRICE_MIN;
            run_len = $urandom_range(1, 30);
            repeat (run_len) begin
                send_price(($urandom_range(7) == 0) ? random_price() : level);
                sent++;
            end
        end
        drain_results();
    endtask

    // zero weight: each ema is just the oldest element of its window
    task automatic test_zero_weights();
        send_idle_pct = 83;
        recv_idle_pct = 14;
        set_weights(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random(250);
        drain_results();
    endtask

    task automatic test_random_weights();
        repeat (6) begin
            set_weights($urandom, $urandom, $urandom);
            run_random(75);
            drain_results();
        end
    endtask

    task automatic test_full_weights();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_weights(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        run_random(200);
        drain_results();
    endtask

    // result side stalls for a long stretch while words keep coming
    task automatic test_backpressure();
        set_weights(DATA_W'(FAST_ALPHA_RST), DATA_W'(SLOW_ALPHA_RST),
                    DATA_W'(SIGNAL_ALPHA_RST));
        -> hold_off_ev;
        run_random(150);
        drain_results();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_access();
        test_window_fill();
        test_default_weights();
        test_macd_saturation();
        test_zero_weights();
        test_random_weights();
        test_full_weights();
        test_backpressure();
        drain_results();
        repeat (WORD_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
sv/wemf_pkg.sv
sv/wemf_mac.sv
sv/windowed_ema_macd_filter.sv
bench/tb_windowed_ema_macd_filter.sv
